// ----- rtl/thm_pkg.sv -----
// ----------------------------------------------------------------------------
// thm_pkg
// Shared types, constants and the 32-bit saturation helper of the solver.
// ----------------------------------------------------------------------------
package thm_pkg;

    localparam int DEF_MAX_ROWS  = 64;
    localparam int DEF_FRAC_BITS = 16;

    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_DIVV_START,
        ST_DIVV,
        ST_DIVU_START,
        ST_DIVU,
        ST_OUT,
        ST_BMUL,
        ST_BADD
    } t_state;

    typedef struct packed {
        logic              clip;
        logic signed [31:0] val;
    } t_sat;

    typedef struct packed {
        logic              done;
        logic              err;
        logic signed [31:0] q;
    } t_div_res;

    function automatic t_sat sat32(input logic signed [63:0] v);
        t_sat r;
        if (v > SAT_MAX) begin
            r.clip = 1'b1;
            r.val  = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r.clip = 1'b1;
            r.val  = 32'sh8000_0000;
        end else begin
            r.clip = 1'b0;
            r.val  = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/thm_div.sv -----
// ----------------------------------------------------------------------------
// thm_div
// Radix-2 restoring divider: signed 64-bit numerator by signed 32-bit
// denominator, quotient truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module thm_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [63:0]    i_num,
    input  logic signed [31:0]    i_den,
    output thm_pkg::t_div_res     o_res
);
    import thm_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic        r_neg;
    logic        r_num_neg;
    logic        r_zero;
    logic [63:0] r_n;
    logic [31:0] r_d;
    logic [31:0] r_rem;

    logic [32:0] trial;
    logic        fits;
    logic signed [63:0] q_signed;
    t_sat        q_sat;

    assign trial = {r_rem, r_n[63]};
    assign fits  = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_neg     <= i_num[63] ^ i_den[31];
                r_num_neg <= i_num[63];
                r_zero    <= (i_den == 32'sd0);
                r_n       <= i_num[63] ? 64'(-i_num) : 64'(i_num);
                r_d       <= i_den[31] ? 32'(-i_den) : 32'(i_den);
                r_rem     <= 32'd0;
                r_cnt     <= 6'd0;
                if (i_den == 32'sd0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                // quotient bits shift in where numerator bits leave
                r_rem <= fits ? 32'(trial - {1'b0, r_d}) : trial[31:0];
                r_n   <= {r_n[62:0], fits};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign q_signed = r_neg ? -$signed(r_n) : $signed(r_n);
    assign q_sat    = sat32(q_signed);

    always_comb begin
        o_res.done = r_done;
        if (r_zero) begin
            o_res.err = 1'b1;
            o_res.q   = r_num_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            o_res.err = q_sat.clip;
            o_res.q   = q_sat.val;
        end
    end

`ifndef SYNTH
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_rem < r_d)
        else $error("remainder out of range");
`endif

endmodule

// ----- rtl/tridiagonal_thomas_solver.sv -----
// Non-final row: after the multiply/setup states the super-diagonal divide and then the
// right-hand-side divide run before the next row is accepted.
// Final row: super-diagonal divide skipped; after the right-hand-side divide the solution
// beats go out through the shared multiplier, held while the output is stalled,
// x[N-1] down to x[0]. Input is stalled while a row or back substitution is in progress.
// Synchronous active-low reset clears control, row count and error flag; stores are not.
// ----------------------------------------------------------------------------
// tridiagonal_thomas_solver
// Streaming Thomas solver: forward sweep per row, back substitution on last.
// ----------------------------------------------------------------------------
module tridiagonal_thomas_solver #(
    parameter int MAX_ROWS  = thm_pkg::DEF_MAX_ROWS,
    parameter int FRAC_BITS = thm_pkg::DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_sub_coef,
    input  logic signed [31:0] i_diag_coef,
    input  logic signed [31:0] i_super_coef,
    input  logic signed [31:0] i_rhs_value,
    input  logic               i_last_row,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_solution_value,
    output logic [5:0]         o_solution_index,
    output logic               o_bad_pivot,
    output logic               o_last_result
);
    import thm_pkg::*;

    localparam int IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ROWS - 1);

    t_state r_state, n_state;

    logic signed [31:0] r_a, r_d, r_c, r_b;
    logic               r_last;
    logic [IW-1:0]      r_i;
    logic [IW-1:0]      r_row_count, n_row_count;
    logic               r_err, n_err;
    logic signed [31:0] r_den, n_den;
    logic signed [63:0] r_unum, n_unum;
    logic signed [31:0] r_vnew, n_vnew;
    logic signed [31:0] r_x, n_x;
    logic [IW-1:0]      r_k, n_k;
    logic signed [63:0] r_prod;

    logic               r_out_valid, n_out_valid;
    logic signed [31:0] r_out_val, n_out_val;
    logic [IW-1:0]      r_out_idx, n_out_idx;
    logic               r_out_bad, n_out_bad;
    logic               r_out_last, n_out_last;

    logic signed [31:0] v_mem [MAX_ROWS];
    logic signed [31:0] u_mem [MAX_ROWS];
    logic signed [31:0] r_v_rd, r_u_rd;
    logic [IW-1:0]      rd_addr;
    logic               mem_we;

    logic signed [31:0] mul_a, mul_b;
    logic               accept, out_free;
    logic               div_start;
    logic signed [63:0] div_num;
    t_div_res           div_res;

    logic signed [63:0] den_sum, bs_sum;
    t_sat               den_sat, bs_sat;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    thm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (r_den),
        .o_res  (div_res)
    );

    // coefficient stores
    always_comb begin
        case (r_state)
            ST_IDLE:                  rd_addr = r_row_count - IW'(1);
            ST_OUT, ST_BMUL, ST_BADD: rd_addr = r_k - IW'(1);
            default:                  rd_addr = r_i - IW'(1);
        endcase
    end

    assign mem_we = (r_state == ST_DIVU) && div_res.done;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            v_mem[r_i] <= r_vnew;
            u_mem[r_i] <= div_res.q;
        end
        r_v_rd <= v_mem[rd_addr];
        r_u_rd <= u_mem[rd_addr];
    end

    // shared multiplier
    always_comb begin
        case (r_state)
            ST_MUL1: begin
                mul_a = r_a;
                mul_b = (r_i == '0) ? 32'sd0 : r_v_rd;
            end
            ST_MUL2: begin
                mul_a = r_a;
                mul_b = (r_i == '0) ? 32'sd0 : r_u_rd;
            end
            ST_BMUL: begin
                mul_a = r_v_rd;
                mul_b = r_x;
            end
            default: begin
                mul_a = 32'sd0;
                mul_b = 32'sd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    assign den_sum = -($signed(64'(r_d)) <<< FRAC_BITS) - r_prod;
    assign den_sat = sat32(den_sum >>> FRAC_BITS);
    assign bs_sum  = (r_prod >>> FRAC_BITS) + $signed(64'(r_u_rd));
    assign bs_sat  = sat32(bs_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row_count <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_count <= n_row_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a    <= i_sub_coef;
            r_d    <= i_diag_coef;
            r_c    <= i_super_coef;
            r_b    <= i_rhs_value;
            r_last <= i_last_row || (r_row_count == LAST_IDX);
            r_i    <= r_row_count;
        end
        r_den      <= n_den;
        r_unum     <= n_unum;
        r_vnew     <= n_vnew;
        r_x        <= n_x;
        r_k        <= n_k;
        r_out_val  <= n_out_val;
        r_out_idx  <= n_out_idx;
        r_out_bad  <= n_out_bad;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_row_count = r_row_count;
        n_err       = r_err;
        n_den       = r_den;
        n_unum      = r_unum;
        n_vnew      = r_vnew;
        n_x         = r_x;
        n_k         = r_k;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_val   = r_out_val;
        n_out_idx   = r_out_idx;
        n_out_bad   = r_out_bad;
        n_out_last  = r_out_last;
        div_start   = 1'b0;
        div_num     = r_unum;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1: begin
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                n_den   = den_sat.val;
                n_err   = r_err | den_sat.clip;
                n_state = ST_DIVV_START;
            end
            ST_DIVV_START: begin
                n_unum = r_prod - ($signed(64'(r_b)) <<< FRAC_BITS);
                if (r_last) begin
                    n_vnew  = 32'sd0;
                    n_state = ST_DIVU_START;
                end else begin
                    div_start = 1'b1;
                    div_num   = $signed(64'(r_c)) <<< FRAC_BITS;
                    n_state   = ST_DIVV;
                end
            end
            ST_DIVV: begin
                if (div_res.done) begin
                    n_vnew  = div_res.q;
                    n_err   = r_err | div_res.err;
                    n_state = ST_DIVU_START;
                end
            end
            ST_DIVU_START: begin
                div_start = 1'b1;
                n_state   = ST_DIVU;
            end
            ST_DIVU: begin
                if (div_res.done) begin
                    n_err = r_err | div_res.err;
                    if (r_last) begin
                        n_x     = div_res.q;
                        n_k     = r_i;
                        n_state = ST_OUT;
                    end else begin
                        n_row_count = r_row_count + IW'(1);
                        n_state     = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_val   = r_x;
                    n_out_idx   = r_k;
                    n_out_bad   = r_err;
                    n_out_last  = (r_k == '0);
                    if (r_k == '0) begin
                        n_row_count = '0;
                        n_err       = 1'b0;
                        n_state     = ST_IDLE;
                    end else begin
                        n_state = ST_BMUL;
                    end
                end
            end
            ST_BMUL: begin
                n_state = ST_BADD;
            end
            ST_BADD: begin
                n_x     = bs_sat.val;
                n_err   = r_err | bs_sat.clip;
                n_k     = r_k - IW'(1);
                n_state = ST_OUT;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_solution_value = r_out_val;
    assign o_solution_index = 6'(r_out_idx);
    assign o_bad_pivot      = r_out_bad;
    assign o_last_result    = r_out_last;

`ifndef SYNTH
    a_last_idx0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_result) |-> (o_solution_index == 6'd0))
        else $error("last beat not at index zero");
    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && out_free && r_k == '0) |=> (r_row_count == '0 && !r_err))
        else $error("run state not cleared after last beat");
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("row accepted without going busy");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVU && div_res.done && !r_last) |-> (r_i != LAST_IDX))
        else $error("row count overrun");
`endif

endmodule
